// File: hw/rtl/rdm_pkg.sv
package rdm_pkg;

	localparam int CLIENTS_DEF = 16;
	localparam int NUM_KINDS   = 3;
	localparam int CNT_W       = 8;
	localparam int FREED_W     = 5;
	localparam int TOTAL_W     = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int ID_W        = 5;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 80;

	localparam logic [CNT_W-1:0]   RESET_RUNWAY_CAP = 8'd3;
	localparam logic [CNT_W-1:0]   RESET_GATE_CAP   = 8'd5;
	localparam logic [CNT_W-1:0]   RESET_TOWER_CAP  = 8'd2;
	localparam logic [CNT_W-1:0]   RESET_WARN_LIMIT = 8'd3;
	localparam logic [CNT_W-1:0]   WARN_MAX         = 8'hFF;
	localparam logic [FREED_W-1:0] FREED_MAX        = 5'd31;

	typedef enum logic [2:0] {
		OP_ALLOC     = 3'd0,
		OP_RELEASE   = 3'd1,
		OP_REQUEST   = 3'd2,
		OP_CLEAR_REQ = 3'd3,
		OP_TICK      = 3'd4,
		OP_WATCH     = 3'd5,
		OP_CLEAR_ALL = 3'd6
	} req_op_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RUNWAY_CAP = 2'd0,
		REG_GATE_CAP   = 2'd1,
		REG_TOWER_CAP  = 2'd2,
		REG_WARN_LIMIT = 2'd3
	} cfg_reg_t;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVT,
		ST_SCAN,
		ST_FORCE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   client_id;
		req_op_t           op;
	} in_item_t;

	// one client's record in the state memory
	typedef struct packed {
		logic                 forced;
		logic [CNT_W-1:0]     warn;
		logic                 watched;
		logic [NUM_KINDS-1:0] wanted;
		logic [NUM_KINDS-1:0] held;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                                err;
		logic [TOTAL_W-1:0]                  forced_total;
		logic [TOTAL_W-1:0]                  dl_total;
		logic [NUM_KINDS-1:0][CNT_W-1:0]     free;
		logic [NUM_KINDS-1:0][FREED_W-1:0]   freed;
		logic                                dl;
	} result_t;

endpackage

// File: hw/rtl/rdm_ram.sv
module rdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/rdm_out_reg.sv
module rdm_out_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  rdm_pkg::result_t                    result,
	output logic                                out_free,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rdm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	logic             valid_q;
	rdm_pkg::result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(rdm_pkg::OUT_TDATA_W - $bits(rdm_pkg::result_t)){1'b0}}, data_q};

endmodule

// File: hw/rtl/rdm_ctrl.sv
module rdm_ctrl #(
	parameter int CLIENTS = rdm_pkg::CLIENTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  rdm_pkg::in_item_t                  in_item,
	input  logic                               cfg_we,
	input  logic [rdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [rdm_pkg::CNT_W-1:0]          cfg_wdata,
	input  logic                               out_free,
	output logic                               out_load,
	output rdm_pkg::result_t                   result,
	output logic                               ram_we,
	output logic [$clog2(CLIENTS)-1:0]         ram_waddr,
	output logic [rdm_pkg::ENTRY_W-1:0]        ram_wdata,
	output logic [$clog2(CLIENTS)-1:0]         ram_raddr,
	input  logic [rdm_pkg::ENTRY_W-1:0]        ram_rdata
);

	localparam int AW = $clog2(CLIENTS);
	localparam int VD = 1 << AW;
	localparam logic [AW-1:0] LAST = AW'(CLIENTS - 1);

	rdm_pkg::state_t  state_q, state_d;
	rdm_pkg::req_op_t op_q, op_d;
	logic [rdm_pkg::KIND_W-1:0] kind_q, kind_d;
	logic [AW-1:0] cidx_q, cidx_d;
	logic [AW-1:0] idx_s1, idx_d;
	logic          rvalid_s1, rvalid_d;
	logic [VD-1:0] valid_q, valid_d;
	logic [1:0]    busy_q, busy_d;
	logic          dl_q, dl_d;
	logic          err_q, err_d;
	logic [rdm_pkg::CNT_W-1:0]   free_q [rdm_pkg::NUM_KINDS];
	logic [rdm_pkg::CNT_W-1:0]   free_d [rdm_pkg::NUM_KINDS];
	logic [rdm_pkg::CNT_W-1:0]   cap_q  [rdm_pkg::NUM_KINDS];
	logic [rdm_pkg::FREED_W-1:0] freed_q [rdm_pkg::NUM_KINDS];
	logic [rdm_pkg::FREED_W-1:0] freed_d [rdm_pkg::NUM_KINDS];
	logic [rdm_pkg::CNT_W-1:0]   limit_q;
	logic [rdm_pkg::TOTAL_W-1:0] dl_total_q, dl_total_d;
	logic [rdm_pkg::TOTAL_W-1:0] forced_total_q, forced_total_d;

	logic                           in_fire;
	logic                           id_ok;
	logic [AW-1:0]                  in_cidx;
	rdm_pkg::entry_t                ent;
	rdm_pkg::entry_t                nent;
	logic                           ent_busy;
	logic [1:0]                     busy_n;
	logic                           blocked;
	logic [rdm_pkg::NUM_KINDS-1:0]  kbit;

	assign in_ready = (state_q == rdm_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign id_ok    = (in_item.client_id != '0) && (int'(in_item.client_id) <= CLIENTS);
	assign in_cidx  = AW'(int'(in_item.client_id) - 1);

	// entries never written since reset or clear all read as zero
	assign ent      = rvalid_s1 ? rdm_pkg::entry_t'(ram_rdata) : '0;
	assign ent_busy = (|ent.held) && (|ent.wanted);
	assign busy_n   = (busy_q == 2'd2) ? 2'd2 : busy_q + {1'b0, ent_busy};
	assign blocked  = ((free_q[0] == '0) && (free_q[1] == '0)) ||
	                  ((free_q[0] == '0) && (free_q[2] == '0)) ||
	                  ((free_q[1] == '0) && (free_q[2] == '0));
	assign kbit     = rdm_pkg::NUM_KINDS'(1 << kind_q);

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		kind_d         = kind_q;
		cidx_d         = cidx_q;
		idx_d          = idx_s1;
		rvalid_d       = rvalid_s1;
		valid_d        = valid_q;
		busy_d         = busy_q;
		dl_d           = dl_q;
		err_d          = err_q;
		free_d         = free_q;
		freed_d        = freed_q;
		dl_total_d     = dl_total_q;
		forced_total_d = forced_total_q;
		nent           = ent;
		ram_we         = 1'b0;
		ram_waddr      = idx_s1;
		ram_raddr      = idx_s1 + AW'(1);
		out_load       = 1'b0;

		case (state_q)
			rdm_pkg::ST_IDLE: begin
				ram_raddr = (in_item.op == rdm_pkg::OP_TICK) ? '0 : in_cidx;
				if (in_fire) begin
					op_d     = in_item.op;
					kind_d   = in_item.kind;
					cidx_d   = in_cidx;
					idx_d    = ram_raddr;
					rvalid_d = valid_q[ram_raddr];
					dl_d     = 1'b0;
					err_d    = 1'b0;
					for (int t = 0; t < rdm_pkg::NUM_KINDS; t++) begin
						freed_d[t] = '0;
					end
					case (in_item.op)
						rdm_pkg::OP_ALLOC, rdm_pkg::OP_RELEASE,
						rdm_pkg::OP_REQUEST, rdm_pkg::OP_CLEAR_REQ: begin
							state_d = (id_ok && in_item.kind != rdm_pkg::KIND_NONE) ?
							          rdm_pkg::ST_EVT : rdm_pkg::ST_DONE;
						end
						rdm_pkg::OP_WATCH: begin
							state_d = id_ok ? rdm_pkg::ST_EVT : rdm_pkg::ST_DONE;
						end
						rdm_pkg::OP_TICK: begin
							busy_d  = 2'd0;
							state_d = rdm_pkg::ST_SCAN;
						end
						rdm_pkg::OP_CLEAR_ALL: begin
							valid_d        = '0;
							free_d         = cap_q;
							dl_total_d     = '0;
							forced_total_d = '0;
							state_d        = rdm_pkg::ST_DONE;
						end
						default: begin
							state_d = rdm_pkg::ST_DONE;
						end
					endcase
				end
			end

			rdm_pkg::ST_EVT: begin
				case (op_q)
					rdm_pkg::OP_ALLOC: begin
						nent.held = ent.held | kbit;
						if (free_q[kind_q] == '0) begin
							err_d = 1'b1;
						end else begin
							free_d[kind_q] = free_q[kind_q] - 1'b1;
						end
					end
					rdm_pkg::OP_RELEASE: begin
						nent.held = ent.held & ~kbit;
						if (free_q[kind_q] >= cap_q[kind_q]) begin
							err_d = 1'b1;
						end else begin
							free_d[kind_q] = free_q[kind_q] + 1'b1;
						end
					end
					rdm_pkg::OP_REQUEST: begin
						nent.wanted = ent.wanted | kbit;
					end
					rdm_pkg::OP_CLEAR_REQ: begin
						nent.wanted = ent.wanted & ~kbit;
					end
					rdm_pkg::OP_WATCH: begin
						nent.watched = 1'b1;
					end
					default: begin
					end
				endcase
				ram_we           = 1'b1;
				ram_waddr        = cidx_q;
				valid_d[cidx_q]  = 1'b1;
				state_d          = rdm_pkg::ST_DONE;
			end

			// first pass: count clients that hold and want
			rdm_pkg::ST_SCAN: begin
				busy_d = busy_n;
				if (idx_s1 == LAST) begin
					if (busy_n == 2'd2 && blocked) begin
						dl_d       = 1'b1;
						dl_total_d = dl_total_q + 1'b1;
						ram_raddr  = '0;
						idx_d      = '0;
						rvalid_d   = valid_q[0];
						state_d    = rdm_pkg::ST_FORCE;
					end else begin
						state_d = rdm_pkg::ST_DONE;
					end
				end else begin
					idx_d    = ram_raddr;
					rvalid_d = valid_q[ram_raddr];
				end
			end

			// second pass: warnings, then forced release in client order
			rdm_pkg::ST_FORCE: begin
				if (ent.watched && ent_busy && ent.warn != rdm_pkg::WARN_MAX) begin
					nent.warn = ent.warn + 1'b1;
				end
				if (nent.watched && !nent.forced && nent.warn >= limit_q) begin
					for (int t = 0; t < rdm_pkg::NUM_KINDS; t++) begin
						if (ent.held[t]) begin
							if (free_q[t] >= cap_q[t]) begin
								err_d = 1'b1;
							end else begin
								free_d[t] = free_q[t] + 1'b1;
							end
							if (freed_q[t] != rdm_pkg::FREED_MAX) begin
								freed_d[t] = freed_q[t] + 1'b1;
							end
						end
					end
					nent.held      = '0;
					nent.forced    = 1'b1;
					nent.watched   = 1'b0;
					forced_total_d = forced_total_q + 1'b1;
				end
				ram_we          = 1'b1;
				valid_d[idx_s1] = 1'b1;
				if (idx_s1 == LAST) begin
					state_d = rdm_pkg::ST_DONE;
				end else begin
					idx_d    = ram_raddr;
					rvalid_d = valid_q[ram_raddr];
				end
			end

			rdm_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = rdm_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = rdm_pkg::ST_IDLE;
			end
		endcase
	end

	assign ram_wdata = nent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q           <= rdm_pkg::OP_ALLOC;
			kind_q         <= '0;
			cidx_q         <= '0;
			idx_s1         <= '0;
			rvalid_s1      <= 1'b0;
			valid_q        <= '0;
			busy_q         <= '0;
			dl_q           <= 1'b0;
			err_q          <= 1'b0;
			free_q[0]      <= rdm_pkg::RESET_RUNWAY_CAP;
			free_q[1]      <= rdm_pkg::RESET_GATE_CAP;
			free_q[2]      <= rdm_pkg::RESET_TOWER_CAP;
			freed_q[0]     <= '0;
			freed_q[1]     <= '0;
			freed_q[2]     <= '0;
			dl_total_q     <= '0;
			forced_total_q <= '0;
		end else begin
			op_q           <= op_d;
			kind_q         <= kind_d;
			cidx_q         <= cidx_d;
			idx_s1         <= idx_d;
			rvalid_s1      <= rvalid_d;
			valid_q        <= valid_d;
			busy_q         <= busy_d;
			dl_q           <= dl_d;
			err_q          <= err_d;
			free_q         <= free_d;
			freed_q        <= freed_d;
			dl_total_q     <= dl_total_d;
			forced_total_q <= forced_total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q[0] <= rdm_pkg::RESET_RUNWAY_CAP;
			cap_q[1] <= rdm_pkg::RESET_GATE_CAP;
			cap_q[2] <= rdm_pkg::RESET_TOWER_CAP;
			limit_q  <= rdm_pkg::RESET_WARN_LIMIT;
		end else if (cfg_we) begin
			case (rdm_pkg::cfg_reg_t'(cfg_addr))
				rdm_pkg::REG_RUNWAY_CAP: cap_q[0] <= cfg_wdata;
				rdm_pkg::REG_GATE_CAP:   cap_q[1] <= cfg_wdata;
				rdm_pkg::REG_TOWER_CAP:  cap_q[2] <= cfg_wdata;
				rdm_pkg::REG_WARN_LIMIT: limit_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		result.dl           = dl_q;
		result.err          = err_q;
		result.dl_total     = dl_total_q;
		result.forced_total = forced_total_q;
		for (int t = 0; t < rdm_pkg::NUM_KINDS; t++) begin
			result.free[t]  = free_q[t];
			result.freed[t] = freed_q[t];
		end
	end

endmodule

// File: hw/rtl/resource_deadlock_monitor.sv
// Allocate, release, request, clear request and watch pass through the event state to the
// done state; clear all and ignored items go straight to done; a check tick makes a scan pass,
// and a forced-release pass when deadlock is found (one state-memory read per client per pass).
// One item at a time; the result loads once the output register is free, and the next item is taken in the cycle after.
// Reset (arst_n low) restores capacities, limit, free counts and totals and marks every
// client entry invalid at once; there is no clearing pass.
module resource_deadlock_monitor #(
	parameter int CLIENTS = rdm_pkg::CLIENTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// req_type[2:0], client_id[7:3], resource_kind[9:8], zero fill
	input  logic [rdm_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// deadlock_found[0], freed_runways[5:1], freed_gates[10:6], freed_towers[15:11],
	// runways_free[23:16], gates_free[31:24], towers_free[39:32],
	// deadlock_total[55:40], forced_total[71:56], bound_error[72], zero fill
	output logic [rdm_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [rdm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [rdm_pkg::CNT_W-1:0]           cfg_wdata
);

	localparam int AW = $clog2(CLIENTS);

	rdm_pkg::in_item_t             item;
	rdm_pkg::result_t              result;
	logic                          out_free;
	logic                          out_load;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [AW-1:0]                 ram_raddr;
	logic [rdm_pkg::ENTRY_W-1:0]   ram_wdata;
	logic [rdm_pkg::ENTRY_W-1:0]   ram_rdata;

	assign item.op        = rdm_pkg::req_op_t'(s_tdata[2:0]);
	assign item.client_id = s_tdata[7:3];
	assign item.kind      = s_tdata[9:8];

	rdm_ctrl #(
		.CLIENTS (CLIENTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.out_load  (out_load),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	rdm_ram #(
		.WIDTH (rdm_pkg::ENTRY_W),
		.DEPTH (CLIENTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rdm_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.result   (result),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: hw/rtl/rdm_checker.sv
module rdm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rdm_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// one item in flight: intake closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous still in work");

	// units are only force-released on a deadlock tick
	a_freed_needs_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[15:1] == '0))
		else $error("freed units reported without deadlock");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind resource_deadlock_monitor rdm_checker u_rdm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: verif/testbench.sv
module testbench;

	localparam int CLIENTS     = rdm_pkg::CLIENTS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 2 * CLIENTS + 8;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	// req_type[2:0], client_id[7:3], resource_kind[9:8], zero fill
	logic [rdm_pkg::IN_TDATA_W-1:0]      s_tdata   = '0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	// deadlock_found[0], freed_runways[5:1], freed_gates[10:6], freed_towers[15:11],
	// runways_free[23:16], gates_free[31:24], towers_free[39:32],
	// deadlock_total[55:40], forced_total[71:56], bound_error[72], zero fill
	logic [rdm_pkg::OUT_TDATA_W-1:0]     m_tdata;
	logic                                cfg_we    = 1'b0;
	logic [rdm_pkg::CFG_ADDR_W-1:0]      cfg_addr  = '0;
	logic [rdm_pkg::CNT_W-1:0]           cfg_wdata = '0;

	resource_deadlock_monitor #(.CLIENTS(CLIENTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the monitor's tracking state
	logic [rdm_pkg::CNT_W-1:0]     capacity [rdm_pkg::NUM_KINDS];
	logic [rdm_pkg::CNT_W-1:0]     warn_limit;
	logic [rdm_pkg::NUM_KINDS-1:0] held_mask [CLIENTS];
	logic [rdm_pkg::NUM_KINDS-1:0] want_mask [CLIENTS];
	logic [rdm_pkg::CNT_W-1:0]     free_units [rdm_pkg::NUM_KINDS];
	logic                          on_watch [CLIENTS];
	logic [rdm_pkg::CNT_W-1:0]     warn_cnt [CLIENTS];
	logic                          was_forced [CLIENTS];
	logic [rdm_pkg::TOTAL_W-1:0]   dl_count;
	logic [rdm_pkg::TOTAL_W-1:0]   forced_count;

	rdm_pkg::result_t pending_results [$];
	rdm_pkg::result_t seen_result;
	rdm_pkg::result_t due_result;

	int send_idle_pct = 12;
	int recv_idle_pct = 77;
	int error_count = 0;
	int results_checked = 0;
	int deadlock_hits = 0;
	int bound_hits = 0;
	int units_reclaimed = 0;
	int cycle_count = 0;

	function automatic void clear_tracking();
		for (int i = 0; i < CLIENTS; i++) begin
			held_mask[i] = '0;
			want_mask[i] = '0;
			on_watch[i] = 1'b0;
			warn_cnt[i] = '0;
			was_forced[i] = 1'b0;
		end
		for (int k = 0; k < rdm_pkg::NUM_KINDS; k++)
			free_units[k] = capacity[k];
		dl_count = '0;
		forced_count = '0;
	endfunction

	// true when the count already sits at or above capacity
	function automatic logic return_unit(input int k);
		if (free_units[k] >= capacity[k])
			return 1'b1;
		free_units[k] = free_units[k] + 1'b1;
		return 1'b0;
	endfunction

	function automatic rdm_pkg::result_t predict_event(input logic [2:0] op,
			input logic [rdm_pkg::ID_W-1:0] id, input logic [rdm_pkg::KIND_W-1:0] kind);
		rdm_pkg::result_t r;
		logic    id_ok;
		int      c;
		int      busy;
		int      blocked;
		r = '0;
		id_ok = (id >= 1) && (id <= CLIENTS);
		c = id_ok ? int'(id) - 1 : 0;
		case (op)
			rdm_pkg::OP_ALLOC, rdm_pkg::OP_RELEASE,
			rdm_pkg::OP_REQUEST, rdm_pkg::OP_CLEAR_REQ: begin
				if (id_ok && kind != rdm_pkg::KIND_NONE) begin
					case (op)
						rdm_pkg::OP_ALLOC: begin
							held_mask[c][kind] = 1'b1;
							if (free_units[kind] == 0)
								r.err = 1'b1;
							else
								free_units[kind] = free_units[kind] - 1'b1;
						end
						rdm_pkg::OP_RELEASE: begin
							held_mask[c][kind] = 1'b0;
							r.err = return_unit(kind);
						end
						rdm_pkg::OP_REQUEST: want_mask[c][kind] = 1'b1;
						default: want_mask[c][kind] = 1'b0;
					endcase
				end
			end
			rdm_pkg::OP_TICK: begin
				busy = 0;
				blocked = 0;
				for (int i = 0; i < CLIENTS; i++)
					if (held_mask[i] != 0 && want_mask[i] != 0)
						busy++;
				for (int k = 0; k < rdm_pkg::NUM_KINDS; k++)
					if (free_units[k] == 0)
						blocked++;
				if (busy >= 2 && blocked >= 2) begin
					r.dl = 1'b1;
					dl_count = dl_count + 1'b1;
					for (int i = 0; i < CLIENTS; i++)
						if (on_watch[i] && held_mask[i] != 0 && want_mask[i] != 0
								&& warn_cnt[i] != rdm_pkg::WARN_MAX)
							warn_cnt[i] = warn_cnt[i] + 1'b1;
					for (int i = 0; i < CLIENTS; i++) begin
						if (on_watch[i] && !was_forced[i] && warn_cnt[i] >= warn_limit) begin
							for (int k = 0; k < rdm_pkg::NUM_KINDS; k++) begin
								if (held_mask[i][k]) begin
									held_mask[i][k] = 1'b0;
									if (return_unit(k))
										r.err = 1'b1;
									if (r.freed[k] != rdm_pkg::FREED_MAX)
										r.freed[k] = r.freed[k] + 1'b1;
								end
							end
							was_forced[i] = 1'b1;
							on_watch[i] = 1'b0;
							forced_count = forced_count + 1'b1;
						end
					end
				end
			end
			rdm_pkg::OP_WATCH: if (id_ok) on_watch[c] = 1'b1;
			rdm_pkg::OP_CLEAR_ALL: clear_tracking();
			default: ;
		endcase
		for (int k = 0; k < rdm_pkg::NUM_KINDS; k++)
			r.free[k] = free_units[k];
		r.dl_total = dl_count;
		r.forced_total = forced_count;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, field, got, want);
		error_count++;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_result = rdm_pkg::result_t'(m_tdata[$bits(rdm_pkg::result_t)-1:0]);
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				due_result = pending_results.pop_front();
				results_checked++;
				if (due_result.dl) deadlock_hits++;
				if (due_result.err) bound_hits++;
				units_reclaimed += due_result.freed[0] + due_result.freed[1]
					+ due_result.freed[2];
				if (seen_result.dl !== due_result.dl)
					report_mismatch("deadlock_found", seen_result.dl, due_result.dl);
				if (seen_result.freed[0] !== due_result.freed[0])
					report_mismatch("freed_runways", seen_result.freed[0], due_result.freed[0]);
				if (seen_result.freed[1] !== due_result.freed[1])
					report_mismatch("freed_gates", seen_result.freed[1], due_result.freed[1]);
				if (seen_result.freed[2] !== due_result.freed[2])
					report_mismatch("freed_towers", seen_result.freed[2], due_result.freed[2]);
				if (seen_result.free[0] !== due_result.free[0])
					report_mismatch("runways_free", seen_result.free[0], due_result.free[0]);
				if (seen_result.free[1] !== due_result.free[1])
					report_mismatch("gates_free", seen_result.free[1], due_result.free[1]);
				if (seen_result.free[2] !== due_result.free[2])
					report_mismatch("towers_free", seen_result.free[2], due_result.free[2]);
				if (seen_result.dl_total !== due_result.dl_total)
					report_mismatch("deadlock_total", seen_result.dl_total, due_result.dl_total);
				if (seen_result.forced_total !== due_result.forced_total)
					report_mismatch("forced_total", seen_result.forced_total,
						due_result.forced_total);
				if (seen_result.err !== due_result.err)
					report_mismatch("bound_error", seen_result.err, due_result.err);
			end
		end
	end

	// valid stays up between back-to-back items; it only drops for a sender gap or while waiting for idle
	task automatic send_event(input logic [2:0] op, input logic [rdm_pkg::ID_W-1:0] id,
			input logic [rdm_pkg::KIND_W-1:0] kind);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(rdm_pkg::IN_TDATA_W - 3 - rdm_pkg::ID_W - rdm_pkg::KIND_W){1'b0}},
			kind, id, op};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_event(op, id, kind));
	endtask

	task automatic wait_until_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input rdm_pkg::cfg_reg_t idx,
			input logic [rdm_pkg::CNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// new capacities only reach the free counts on clear all; reset restores the default capacities
	task automatic set_config(input logic [rdm_pkg::CNT_W-1:0] runway,
			input logic [rdm_pkg::CNT_W-1:0] gate, input logic [rdm_pkg::CNT_W-1:0] tower,
			input logic [rdm_pkg::CNT_W-1:0] limit);
		write_reg(rdm_pkg::REG_RUNWAY_CAP, runway);
		write_reg(rdm_pkg::REG_GATE_CAP, gate);
		write_reg(rdm_pkg::REG_TOWER_CAP, tower);
		write_reg(rdm_pkg::REG_WARN_LIMIT, limit);
		cfg_we <= 1'b0;
		capacity[0] = runway;
		capacity[1] = gate;
		capacity[2] = tower;
		warn_limit = limit;
	endtask

	task automatic test_directed_events();
		set_config(rdm_pkg::RESET_RUNWAY_CAP, rdm_pkg::RESET_GATE_CAP,
			rdm_pkg::RESET_TOWER_CAP, 8'd1);
		send_event(rdm_pkg::OP_ALLOC, 5'd1, 2'd0);
		send_event(rdm_pkg::OP_ALLOC, 5'd2, 2'd0);
		send_event(rdm_pkg::OP_ALLOC, 5'd3, 2'd0);
		send_event(rdm_pkg::OP_ALLOC, 5'd4, 2'd0);      // no runway left
		send_event(rdm_pkg::OP_ALLOC, 5'd1, 2'd2);
		send_event(rdm_pkg::OP_ALLOC, 5'd2, 2'd2);
		send_event(rdm_pkg::OP_REQUEST, 5'd1, 2'd1);
		send_event(rdm_pkg::OP_REQUEST, 5'd2, 2'd1);
		send_event(rdm_pkg::OP_WATCH, 5'd1, 2'd0);
		send_event(rdm_pkg::OP_ALLOC, 5'd0, 2'd0);      // ids outside 1..16 are ignored
		send_event(rdm_pkg::OP_ALLOC, 5'd17, 2'd1);
		send_event(rdm_pkg::OP_REQUEST, 5'd31, rdm_pkg::KIND_NONE);
		send_event(rdm_pkg::OP_ALLOC, 5'd5, rdm_pkg::KIND_NONE);
		send_event(3'd7, 5'd5, 2'd1);
		send_event(rdm_pkg::OP_RELEASE, 5'd5, 2'd1);    // gates already at capacity
		send_event(rdm_pkg::OP_WATCH, 5'd16, 2'd3);
		send_event(rdm_pkg::OP_TICK, 5'd0, 2'd0);
		send_event(rdm_pkg::OP_TICK, 5'd31, 2'd3);
		send_event(rdm_pkg::OP_WATCH, 5'd1, 2'd0);      // forced once, may rejoin
		send_event(rdm_pkg::OP_CLEAR_REQ, 5'd1, 2'd1);
		send_event(rdm_pkg::OP_CLEAR_ALL, 5'd9, 2'd2);
		wait_until_idle();
	endtask

	task automatic test_forced_at_capacity();
		set_config(8'd0, rdm_pkg::RESET_GATE_CAP, rdm_pkg::RESET_TOWER_CAP, 8'd0);
		send_event(rdm_pkg::OP_RELEASE, 5'd9, 2'd0);    // runway count above the new capacity
		send_event(rdm_pkg::OP_CLEAR_ALL, 5'd0, 2'd0);
		send_event(rdm_pkg::OP_ALLOC, 5'd1, 2'd0);
		send_event(rdm_pkg::OP_ALLOC, 5'd1, 2'd2);
		send_event(rdm_pkg::OP_ALLOC, 5'd2, 2'd2);
		send_event(rdm_pkg::OP_ALLOC, 5'd2, 2'd0);
		send_event(rdm_pkg::OP_REQUEST, 5'd1, 2'd1);
		send_event(rdm_pkg::OP_REQUEST, 5'd2, 2'd1);
		send_event(rdm_pkg::OP_WATCH, 5'd1, 2'd0);
		send_event(rdm_pkg::OP_WATCH, 5'd3, 2'd0);
		send_event(rdm_pkg::OP_TICK, 5'd0, 2'd0);
		wait_until_idle();
	endtask

	task automatic random_traffic(input int count, input int span);
		int roll;
		logic [2:0] op;
		logic [rdm_pkg::ID_W-1:0] id;
		logic [rdm_pkg::KIND_W-1:0] kind;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			id = rdm_pkg::ID_W'($urandom_range(span, 1));
			kind = rdm_pkg::KIND_W'($urandom_range(2));
			if (roll < 24) op = rdm_pkg::OP_ALLOC;
			else if (roll < 42) op = rdm_pkg::OP_RELEASE;
			else if (roll < 58) op = rdm_pkg::OP_REQUEST;
			else if (roll < 68) op = rdm_pkg::OP_CLEAR_REQ;
			else if (roll < 83) op = rdm_pkg::OP_TICK;
			else if (roll < 91) op = rdm_pkg::OP_WATCH;
			else if (roll < 93) op = rdm_pkg::OP_CLEAR_ALL;
			else begin
				// noise: any code, any id, any kind
				op = 3'($urandom_range(7));
				id = rdm_pkg::ID_W'($urandom);
				kind = rdm_pkg::KIND_W'($urandom);
			end
			if (n == count / 2)
				wait_until_idle();
			send_event(op, id, kind);
		end
		wait_until_idle();
	endtask

	task automatic test_random_slow_receiver();
		send_idle_pct = 12;
		recv_idle_pct = 77;
		set_config(8'd1, 8'd2, 8'd1, 8'd2);
		send_event(rdm_pkg::OP_CLEAR_ALL, 5'd0, 2'd0);
		random_traffic(700, 4);
	endtask

	task automatic test_random_slow_sender();
		send_idle_pct = 77;
		recv_idle_pct = 12;
		set_config(8'd255, 8'd0, 8'd3, 8'd255);
		send_event(rdm_pkg::OP_CLEAR_ALL, 5'd0, 2'd0);
		random_traffic(650, CLIENTS);
	endtask

	task automatic test_random_full_rate();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(8'd2, 8'd1, 8'd2, 8'd1);
		send_event(rdm_pkg::OP_CLEAR_ALL, 5'd0, 2'd0);
		random_traffic(650, 6);
	endtask

	initial begin
		capacity[0] = rdm_pkg::RESET_RUNWAY_CAP;
		capacity[1] = rdm_pkg::RESET_GATE_CAP;
		capacity[2] = rdm_pkg::RESET_TOWER_CAP;
		warn_limit = rdm_pkg::RESET_WARN_LIMIT;
		clear_tracking();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_forced_at_capacity();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_full_rate();
		wait_until_idle();
		repeat (SETTLE) @(posedge clk);
		$display("%0d items checked: %0d deadlock ticks, %0d units reclaimed, %0d bound errors",
			results_checked, deadlock_hits, units_reclaimed, bound_hits);
		$display("capacities from 0 to 255, warning limits 0, 1, 2 and 255, three stall mixes");
		if (error_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
